// File: sv/ehbt_pkg.sv
// Package with the word types, opcodes, status codes and controller states of the edge table.
`default_nettype none
package ehbt_pkg;

  localparam int unsigned BucketBits = 8;
  localparam int unsigned ResultCap = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ADD   = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_MATCH = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] concept_a;
    logic [15:0] concept_b;
    logic [7:0]  edge_weight;
    logic [7:0]  relation;
    logic [6:0]  max_wanted;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_source;
    logic [15:0] out_target;
    logic [7:0]  out_weight;
    logic [7:0]  out_relation;
    logic        dropped_full;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_FILL,
    S_RD,
    S_CHK,
    S_STORE1,
    S_FILL2,
    S_STORE2,
    S_EMIT,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic load_in;
    logic clear_step;
    logic fill_rd;
    logic sel_b;
    logic rd_entry;
    logic scan_step;
    logic store;
    logic emit_match;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic clear_done;
    logic scan_end;
    logic hit;
    logic dup;
    logic emit_full;
    logic same_bucket;
    logic out_busy;
  } sts_t;

  function automatic logic [BucketBits-1:0] bucket_of(input logic [15:0] key);
    return key[7:0] ^ key[11:4];
  endfunction

endpackage
`default_nettype wire

// File: sv/ehbt_ctrl.sv
// Controller state machine that sequences clear, store, duplicate scan and query.
`default_nettype none
module ehbt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ehbt_pkg::sts_t sts,
  output ehbt_pkg::cmd_t     cmd
);
  import ehbt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = (sts.opcode == OP_CLEAR) ? S_CLEAR : S_FILL;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_FINAL;
        end
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        state_nxt = (sts.opcode == OP_LOAD) ? S_STORE1 : S_RD;
      end
      S_RD: begin
        if (sts.scan_end) begin
          state_nxt = (sts.opcode == OP_QUERY) ? S_FINAL : S_STORE1;
        end else begin
          cmd.rd_entry = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.opcode == OP_QUERY) begin
          if (sts.hit) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.scan_step = 1'b1;
            state_nxt = S_RD;
          end
        end else if (sts.dup) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit_match = 1'b1;
          cmd.scan_step = 1'b1;
          state_nxt = sts.emit_full ? S_FINAL : S_RD;
        end
      end
      S_STORE1: begin
        cmd.store = 1'b1;
        state_nxt = sts.same_bucket ? S_FINAL : S_FILL2;
      end
      S_FILL2: begin
        cmd.fill_rd = 1'b1;
        cmd.sel_b = 1'b1;
        state_nxt = S_STORE2;
      end
      S_STORE2: begin
        cmd.store = 1'b1;
        cmd.sel_b = 1'b1;
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (!sts.out_busy) begin
          cmd.emit_final = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/ehbt_dpath.sv
// Datapath with the entry memory, fill counts, scan counters and output register.
`default_nettype none
module ehbt_dpath #(
  parameter int unsigned CHAIN_DEPTH = 16,
  parameter int unsigned DEDUP_SCAN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ehbt_pkg::in_word_t in_data,
  input  wire ehbt_pkg::cmd_t    cmd,
  output ehbt_pkg::sts_t         sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ehbt_pkg::out_word_t    out_data
);
  import ehbt_pkg::*;

  localparam int unsigned IdxW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned SeenW = $clog2(DEDUP_SCAN + 1);
  localparam int unsigned AddrW = BucketBits + IdxW;
  localparam int unsigned Buckets = 1 << BucketBits;
  localparam int unsigned Depth = Buckets << IdxW;

  logic [47:0]      ent_mem [Depth];
  logic [FillW-1:0] fill_mem [Buckets];

  in_word_t         req_r;
  logic [FillW-1:0] fill_r;
  logic [FillW-1:0] idx_r;
  logic [SeenW-1:0] seen_r, seen_nxt;
  logic [4:0]       nout_r;
  logic             drop_r;
  logic [47:0]      rd_r;
  logic [47:0]      hold_r;
  logic             rd_ok_r;
  logic [BucketBits-1:0] clr_r;
  logic             out_valid_r;
  out_word_t        out_r;
  out_word_t        fin_word;

  logic [BucketBits-1:0] ha, hb, hsel;
  logic [6:0]  cap;
  logic [47:0] new_ent;
  logic        ends_hit, exact;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [4:0]  nout_next;

  assign ha = bucket_of(req_r.concept_a);
  assign hb = bucket_of(req_r.concept_b);
  assign hsel = cmd.sel_b ? hb : ha;
  assign cap = (req_r.max_wanted < 7'(ResultCap)) ? req_r.max_wanted : 7'(ResultCap);
  assign new_ent = {req_r.concept_a, req_r.concept_b, req_r.edge_weight, req_r.relation};
  assign ends_hit = (rd_r[47:32] == req_r.concept_a) || (rd_r[31:16] == req_r.concept_a);
  assign exact = (rd_r[47:32] == req_r.concept_a) && (rd_r[31:16] == req_r.concept_b)
                 && (rd_r[7:0] == req_r.relation);
  assign rd_addr = {ha, idx_r[IdxW-1:0]};
  assign wr_addr = {hsel, fill_r[IdxW-1:0]};
  assign seen_nxt = seen_r + SeenW'(1);
  assign nout_next = nout_r + 5'd1;

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      fill_mem[clr_r] <= '0;
    end else if (cmd.store && fill_r != FillW'(CHAIN_DEPTH)) begin
      fill_mem[hsel] <= fill_r + FillW'(1);
    end
    if (cmd.fill_rd) begin
      fill_r <= fill_mem[hsel];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && fill_r != FillW'(CHAIN_DEPTH)) begin
      ent_mem[wr_addr] <= new_ent;
    end
    if (cmd.rd_entry) begin
      rd_r <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_r <= clr_r + BucketBits'(1);
      end
      if (cmd.emit_final || (cmd.emit_match && nout_r != 5'd0)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The last match of a query is held back so that it can carry the last flag.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= in_data;
      idx_r <= '0;
      seen_r <= '0;
      nout_r <= '0;
      drop_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + FillW'(1);
    end
    if (cmd.rd_entry) begin
      seen_r <= seen_r;
      rd_ok_r <= 1'b1;
    end
    if (cmd.store && fill_r == FillW'(CHAIN_DEPTH)) begin
      drop_r <= 1'b1;
    end
    if (cmd.emit_match) begin
      nout_r <= nout_next;
      hold_r <= rd_r;
      if (nout_r != 5'd0) begin
        out_r <= '{status: ST_MATCH, out_source: hold_r[47:32], out_target: hold_r[31:16],
                   out_weight: hold_r[15:8], out_relation: hold_r[7:0], dropped_full: 1'b0,
                   last: 1'b0};
      end
    end
    if (cmd.emit_final) begin
      out_r <= fin_word;
    end
    if (sts.opcode == OP_ADD && cmd.scan_step && ends_hit) begin
      seen_r <= seen_nxt;
    end
  end

  always_comb begin
    fin_word = '0;
    fin_word.last = 1'b1;
    if (req_r.opcode == OP_QUERY) begin
      if (nout_r == 5'd0) begin
        fin_word.status = ST_NONE;
      end else begin
        fin_word.status = ST_MATCH;
        fin_word.out_source = hold_r[47:32];
        fin_word.out_target = hold_r[31:16];
        fin_word.out_weight = hold_r[15:8];
        fin_word.out_relation = hold_r[7:0];
      end
    end else if (req_r.opcode == OP_ADD && rd_ok_r && sts.dup) begin
      fin_word.status = ST_DUP;
    end else begin
      fin_word.status = ST_DONE;
      fin_word.dropped_full = drop_r && (req_r.opcode != OP_CLEAR);
    end
  end

  always_comb begin
    sts = '0;
    sts.opcode = cmd.load_in ? in_data.opcode : req_r.opcode;
    sts.clear_done = (clr_r == '1);
    sts.same_bucket = (ha == hb);
    sts.out_busy = out_valid_r && !out_ready;
    sts.hit = ends_hit;
    sts.dup = ends_hit && exact && (req_r.opcode == OP_ADD);
    sts.emit_full = 1'b0;
    if (req_r.opcode == OP_QUERY) begin
      sts.scan_end = (idx_r >= fill_r) || (7'(nout_r) >= cap);
    end else begin
      sts.scan_end = (idx_r >= fill_r) || (seen_r >= SeenW'(DEDUP_SCAN));
    end
    if (7'(nout_next) >= cap) begin
      sts.emit_full = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

// File: sv/edge_hash_bucket_table_top.sv
// Top level of the edge hash bucket table: controller and datapath.
// One item at a time: a new word is accepted only while the controller is idle.
// A bucket scan reads and checks each entry in turn, with an emit step per query match; a busy output adds stalls.
// The final word becomes valid in the same cycle in which the controller is idle again and the next word can be taken.
// Query matches leave one at a time; each is held until the next is known.
// After reset a clearing pass zeroes the fill counts of all buckets, and no word is accepted during it.
`default_nettype none
module edge_hash_bucket_table_top #(
  parameter int unsigned CHAIN_DEPTH = 16,
  parameter int unsigned DEDUP_SCAN = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ehbt_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ehbt_pkg::out_word_t       out_data
);
  import ehbt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ehbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ehbt_dpath #(
    .CHAIN_DEPTH (CHAIN_DEPTH),
    .DEDUP_SCAN  (DEDUP_SCAN)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
